// ----- rtl/fmsd_pkg.sv -----
// Package for the frame mean and standard deviation block.
// Holds field widths, register indexes, sequencing constants and the controller/datapath types.
// No dependencies; every other file of the block takes names from here by scope.
package fmsd_pkg;

  // Default frame size limits.
  localparam int MAX_ROWS_DEF = 1024;
  localparam int MAX_COLS_DEF = 1024;

  // Field widths of the channels.
  localparam int PIX_W      = 8;
  localparam int MEAN_W     = 16;
  localparam int STD_W      = 15;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 2;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 2'd1;

  // The variance quotient floor(65536*d/N^2) stays below 2^30.
  localparam int FRAC_W     = 16;
  localparam int QUO_W      = 30;
  localparam int VAR_PRE    = QUO_W - FRAC_W;
  localparam int MEAN_STEPS = MEAN_W;
  localparam int VAR_STEPS  = QUO_W;
  localparam int SQRT_STEPS = STD_W;
  localparam int SREM_W     = STD_W + 2;
  localparam int CNT_W      = 5;

  localparam logic [MEAN_W-1:0] MEAN_MAX = 16'hFF00;

  // Datapath operations.
  localparam logic [3:0] CMD_NONE     = 4'd0;
  localparam logic [3:0] CMD_MEAN_LD  = 4'd1;
  localparam logic [3:0] CMD_DIV_STEP = 4'd2;
  localparam logic [3:0] CMD_NQ_LD    = 4'd3;
  localparam logic [3:0] CMD_MUL_STEP = 4'd4;
  localparam logic [3:0] CMD_SS_LD    = 4'd5;
  localparam logic [3:0] CMD_NN_LD    = 4'd6;
  localparam logic [3:0] CMD_VAR_LD   = 4'd7;
  localparam logic [3:0] CMD_SQ_LD    = 4'd8;
  localparam logic [3:0] CMD_SQ_STEP  = 4'd9;
  localparam logic [3:0] CMD_FINISH   = 4'd10;

  typedef struct packed {
    logic [3:0] op;
    logic       pix_acc;
  } dp_cmd_t;

  typedef struct packed {
    logic frame_end;
    logic mul_done;
    logic out_free;
  } dp_sts_t;

endpackage

// ----- rtl/fmsd_pix_if.sv -----
// Pixel word channel: valid/ready handshake carrying one grayscale pixel.
// Depends on fmsd_pkg for the pixel width.
interface fmsd_pix_if;
  logic                        valid;
  logic                        ready;
  logic [fmsd_pkg::PIX_W-1:0]  pixel_value;

  modport source (output valid, output pixel_value, input ready);
  modport sink   (input valid, input pixel_value, output ready);
endinterface

// ----- rtl/fmsd_res_if.sv -----
// Result word channel: valid/ready handshake carrying the frame mean and deviation.
// Depends on fmsd_pkg for the field widths.
interface fmsd_res_if;
  logic                         valid;
  logic                         ready;
  logic [fmsd_pkg::MEAN_W-1:0]  mean_q8;
  logic [fmsd_pkg::STD_W-1:0]   std_dev_q8;

  modport source (output valid, output mean_q8, output std_dev_q8, input ready);
  modport sink   (input valid, input mean_q8, input std_dev_q8, output ready);
endinterface

// ----- rtl/fmsd_cfg_if.sv -----
// Configuration write channel: valid/ready handshake carrying a register index and data.
// Depends on fmsd_pkg for the index and data widths.
interface fmsd_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [fmsd_pkg::CFG_IDX_W-1:0]   reg_index;
  logic [fmsd_pkg::CFG_DATA_W-1:0]  wr_data;

  modport source (output valid, output reg_index, output wr_data, input ready);
  modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

// ----- rtl/fmsd_dp.sv -----
// Datapath: frame size registers, accumulators, shift-add multiplier, restoring divider,
// digit-by-digit square root and the result register. Depends on fmsd_pkg.
module fmsd_dp #(
  parameter int MAX_ROWS = fmsd_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = fmsd_pkg::MAX_COLS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  fmsd_pkg::dp_cmd_t                 cmd,
  output fmsd_pkg::dp_sts_t                 sts,
  input  logic                              cfg_valid,
  input  logic [fmsd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fmsd_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [fmsd_pkg::PIX_W-1:0]        pixel_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [fmsd_pkg::MEAN_W-1:0]       mean_q8,
  output logic [fmsd_pkg::STD_W-1:0]        std_dev_q8
);

  localparam int ROW_W  = $clog2(MAX_ROWS + 1);
  localparam int COL_W  = $clog2(MAX_COLS + 1);
  localparam int N_MAX  = MAX_ROWS * MAX_COLS;
  localparam int N_W    = $clog2(N_MAX + 1);
  localparam int SUM_W  = N_W + fmsd_pkg::PIX_W;
  localparam int SQ_W   = N_W + 2 * fmsd_pkg::PIX_W;
  localparam int PROD_W = 2 * N_W + 2 * fmsd_pkg::PIX_W;
  localparam int NN_W   = 2 * N_W;
  localparam int QW     = fmsd_pkg::QUO_W;
  localparam int SRW    = fmsd_pkg::SREM_W;
  localparam int PRE    = fmsd_pkg::VAR_PRE;

  // A zero dimension counts as one; an oversized one saturates.
  function automatic int clamp_dim(logic [fmsd_pkg::CFG_DATA_W-1:0] v, int top);
    int r;
    r = int'(v);
    if (r == 0) begin
      r = 1;
    end else if (r > top) begin
      r = top;
    end
    return r;
  endfunction

  // Frame size.
  logic [ROW_W-1:0]       rows_r, rows_sel;
  logic [COL_W-1:0]       cols_r, cols_sel;
  logic [N_W-1:0]         size_r;
  logic [ROW_W+COL_W-1:0] size_prod;

  // Accumulators.
  logic [N_W-1:0]                  seen_r, seen_inc;
  logic [SUM_W-1:0]                sum_r;
  logic [SQ_W-1:0]                 sq_r;
  logic [2*fmsd_pkg::PIX_W-1:0]    pix_sq;

  // Arithmetic units.
  logic [PROD_W-1:0]             acc_r, mcand_r, d_r;
  logic [SUM_W-1:0]              mplier_r;
  logic [NN_W-1:0]               div_rem_r, div_den_r, div_diff;
  logic [NN_W:0]                 div_t;
  logic                          div_ge;
  logic [QW-1:0]                 div_lo_r, quo_r;
  logic [fmsd_pkg::MEAN_W-1:0]   mean_r;
  logic [QW-1:0]                 sq_x_r;
  logic [SRW-1:0]                sq_rem_r;
  logic [SRW+1:0]                sq_t, sq_trial;
  logic                          sq_ge;
  logic [fmsd_pkg::STD_W-1:0]    root_r;

  // Result register.
  logic                          out_valid_r;
  logic [fmsd_pkg::MEAN_W-1:0]   out_mean_r;
  logic [fmsd_pkg::STD_W-1:0]    out_std_r;

  always_comb begin
    rows_sel = rows_r;
    cols_sel = cols_r;
    if (cfg_valid && (cfg_index == fmsd_pkg::REG_ROW_COUNT)) begin
      rows_sel = ROW_W'(clamp_dim(cfg_data, MAX_ROWS));
    end
    if (cfg_valid && (cfg_index == fmsd_pkg::REG_COLUMN_COUNT)) begin
      cols_sel = COL_W'(clamp_dim(cfg_data, MAX_COLS));
    end
  end

  assign size_prod = (ROW_W+COL_W)'(rows_sel) * (ROW_W+COL_W)'(cols_sel);
  assign seen_inc  = seen_r + N_W'(1);
  assign pix_sq    = pixel_value * pixel_value;

  assign div_t    = {div_rem_r, div_lo_r[QW-1]};
  assign div_ge   = div_t >= {1'b0, div_den_r};
  assign div_diff = NN_W'(div_t - {1'b0, div_den_r});

  assign sq_t     = {sq_rem_r, sq_x_r[QW-1 -: 2]};
  assign sq_trial = (SRW+2)'({root_r, 2'b01});
  assign sq_ge    = sq_t >= sq_trial;

  assign sts.frame_end = seen_inc >= size_r;
  assign sts.mul_done  = (mplier_r == '0);
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid  = out_valid_r;
  assign mean_q8    = out_mean_r;
  assign std_dev_q8 = out_std_r;

  // Control state: size, accumulators and result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r      <= ROW_W'(1);
      cols_r      <= COL_W'(1);
      size_r      <= N_W'(1);
      seen_r      <= '0;
      sum_r       <= '0;
      sq_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rows_r <= rows_sel;
      cols_r <= cols_sel;
      size_r <= size_prod[N_W-1:0];
      if (cmd.pix_acc) begin
        seen_r <= seen_inc;
        sum_r  <= sum_r + SUM_W'(pixel_value);
        sq_r   <= sq_r + SQ_W'(pix_sq);
      end
      if (cmd.op == fmsd_pkg::CMD_FINISH) begin
        seen_r      <= '0;
        sum_r       <= '0;
        sq_r        <= '0;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Arithmetic registers, sequenced by the controller.
  always_ff @(posedge clk) begin
    case (cmd.op)
      fmsd_pkg::CMD_MEAN_LD: begin
        // 256*S/N: the top bits of S start the remainder, its low byte and zeros follow.
        div_rem_r <= NN_W'(sum_r[SUM_W-1:fmsd_pkg::PIX_W]);
        div_lo_r  <= {sum_r[fmsd_pkg::PIX_W-1:0], (QW-fmsd_pkg::PIX_W)'(0)};
        div_den_r <= NN_W'(seen_r);
        quo_r     <= '0;
      end
      fmsd_pkg::CMD_DIV_STEP: begin
        div_rem_r <= div_ge ? div_diff : div_t[NN_W-1:0];
        div_lo_r  <= div_lo_r << 1;
        quo_r     <= {quo_r[QW-2:0], div_ge};
      end
      fmsd_pkg::CMD_NQ_LD: begin
        mean_r   <= quo_r[fmsd_pkg::MEAN_W-1:0];
        acc_r    <= '0;
        mcand_r  <= PROD_W'(sq_r);
        mplier_r <= SUM_W'(seen_r);
      end
      fmsd_pkg::CMD_MUL_STEP: begin
        if (mplier_r[0]) begin
          acc_r <= acc_r + mcand_r;
        end
        mcand_r  <= mcand_r << 1;
        mplier_r <= mplier_r >> 1;
      end
      fmsd_pkg::CMD_SS_LD: begin
        d_r      <= acc_r;
        acc_r    <= '0;
        mcand_r  <= PROD_W'(sum_r);
        mplier_r <= sum_r;
      end
      fmsd_pkg::CMD_NN_LD: begin
        d_r      <= d_r - acc_r;
        acc_r    <= '0;
        mcand_r  <= PROD_W'(seen_r);
        mplier_r <= SUM_W'(seen_r);
      end
      fmsd_pkg::CMD_VAR_LD: begin
        // 65536*d/N^2: d >> 14 is already below N^2 since the quotient fits 30 bits.
        div_rem_r <= d_r[NN_W+PRE-1:PRE];
        div_lo_r  <= {d_r[PRE-1:0], (QW-PRE)'(0)};
        div_den_r <= acc_r[NN_W-1:0];
        quo_r     <= '0;
      end
      fmsd_pkg::CMD_SQ_LD: begin
        sq_x_r   <= quo_r;
        sq_rem_r <= '0;
        root_r   <= '0;
      end
      fmsd_pkg::CMD_SQ_STEP: begin
        sq_x_r <= sq_x_r << 2;
        if (sq_ge) begin
          sq_rem_r <= SRW'(sq_t - sq_trial);
          root_r   <= {root_r[fmsd_pkg::STD_W-2:0], 1'b1};
        end else begin
          sq_rem_r <= sq_t[SRW-1:0];
          root_r   <= {root_r[fmsd_pkg::STD_W-2:0], 1'b0};
        end
      end
      fmsd_pkg::CMD_FINISH: begin
        out_mean_r <= mean_r;
        out_std_r  <= root_r;
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  a_div_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == fmsd_pkg::CMD_DIV_STEP) |-> (div_rem_r < div_den_r))
    else $error("divider remainder not below divisor");

  a_mean_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_mean_r <= fmsd_pkg::MEAN_MAX))
    else $error("mean above 255.0");

  a_acc_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == fmsd_pkg::CMD_FINISH) |=> (seen_r == '0 && sum_r == '0 && sq_r == '0))
    else $error("accumulators not cleared after a frame");
`endif

endmodule

// ----- rtl/fmsd_ctrl.sv -----
// Controller: state machine that sequences accumulation, the multiply, divide and root steps.
// Depends on fmsd_pkg for the command and status types.
module fmsd_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  fmsd_pkg::dp_sts_t  sts,
  output fmsd_pkg::dp_cmd_t  cmd
);

  localparam logic [3:0] S_ACC      = 4'd0;
  localparam logic [3:0] S_MEAN_LD  = 4'd1;
  localparam logic [3:0] S_MEAN_DIV = 4'd2;
  localparam logic [3:0] S_NQ_LD    = 4'd3;
  localparam logic [3:0] S_NQ_MUL   = 4'd4;
  localparam logic [3:0] S_SS_LD    = 4'd5;
  localparam logic [3:0] S_SS_MUL   = 4'd6;
  localparam logic [3:0] S_NN_LD    = 4'd7;
  localparam logic [3:0] S_NN_MUL   = 4'd8;
  localparam logic [3:0] S_VAR_LD   = 4'd9;
  localparam logic [3:0] S_VAR_DIV  = 4'd10;
  localparam logic [3:0] S_SQ_LD    = 4'd11;
  localparam logic [3:0] S_SQ_RUN   = 4'd12;
  localparam logic [3:0] S_DONE     = 4'd13;

  localparam int CW = fmsd_pkg::CNT_W;

  logic [3:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign in_ready = (state_r == S_ACC);

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    cmd.op      = fmsd_pkg::CMD_NONE;
    cmd.pix_acc = in_ready && in_valid;
    case (state_r)
      S_ACC: begin
        if (cmd.pix_acc && sts.frame_end) begin
          state_nxt = S_MEAN_LD;
        end
      end
      S_MEAN_LD: begin
        cmd.op    = fmsd_pkg::CMD_MEAN_LD;
        cnt_nxt   = '0;
        state_nxt = S_MEAN_DIV;
      end
      S_MEAN_DIV: begin
        cmd.op  = fmsd_pkg::CMD_DIV_STEP;
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CW'(fmsd_pkg::MEAN_STEPS - 1)) begin
          state_nxt = S_NQ_LD;
        end
      end
      S_NQ_LD: begin
        cmd.op    = fmsd_pkg::CMD_NQ_LD;
        state_nxt = S_NQ_MUL;
      end
      S_NQ_MUL: begin
        if (sts.mul_done) begin
          state_nxt = S_SS_LD;
        end else begin
          cmd.op = fmsd_pkg::CMD_MUL_STEP;
        end
      end
      S_SS_LD: begin
        cmd.op    = fmsd_pkg::CMD_SS_LD;
        state_nxt = S_SS_MUL;
      end
      S_SS_MUL: begin
        if (sts.mul_done) begin
          state_nxt = S_NN_LD;
        end else begin
          cmd.op = fmsd_pkg::CMD_MUL_STEP;
        end
      end
      S_NN_LD: begin
        cmd.op    = fmsd_pkg::CMD_NN_LD;
        state_nxt = S_NN_MUL;
      end
      S_NN_MUL: begin
        if (sts.mul_done) begin
          state_nxt = S_VAR_LD;
        end else begin
          cmd.op = fmsd_pkg::CMD_MUL_STEP;
        end
      end
      S_VAR_LD: begin
        cmd.op    = fmsd_pkg::CMD_VAR_LD;
        cnt_nxt   = '0;
        state_nxt = S_VAR_DIV;
      end
      S_VAR_DIV: begin
        cmd.op  = fmsd_pkg::CMD_DIV_STEP;
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CW'(fmsd_pkg::VAR_STEPS - 1)) begin
          state_nxt = S_SQ_LD;
        end
      end
      S_SQ_LD: begin
        cmd.op    = fmsd_pkg::CMD_SQ_LD;
        cnt_nxt   = '0;
        state_nxt = S_SQ_RUN;
      end
      S_SQ_RUN: begin
        cmd.op  = fmsd_pkg::CMD_SQ_STEP;
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CW'(fmsd_pkg::SQRT_STEPS - 1)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.op    = fmsd_pkg::CMD_FINISH;
          state_nxt = S_ACC;
        end
      end
      default: begin
        state_nxt = S_ACC;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_ACC;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// ----- rtl/frame_mean_and_std_dev.sv -----
// Top level of the frame mean and population standard deviation block.
// Instantiates fmsd_ctrl and fmsd_dp; uses fmsd_pkg and the three channel interfaces.
//
//   Channel   Direction  Handshake     Word contents
//   in_pix    sink       valid/ready   pixel_value[7:0]
//   out_res   source     valid/ready   mean_q8[15:0], std_dev_q8[14:0]
//   cfg_wr    sink       valid/ready   reg_index[1:0], wr_data[10:0]
//
// Pixels are taken one per cycle. The pixel that completes a frame starts a
// sequencer run, during which in_pix.ready is low; that run is the shift-add
// multiplier, the restoring divider and the root unit. The result waits in an
// output register, so the next frame streams in while it is unread; beyond the
// sequencer run, only a second frame end before the first result is taken
// stalls the input.
// Reset is synchronous and active low; it sets both dimensions to one.
module frame_mean_and_std_dev #(
  parameter int MAX_ROWS = fmsd_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = fmsd_pkg::MAX_COLS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  fmsd_cfg_if.sink           cfg_wr,
  fmsd_pix_if.sink           in_pix,
  fmsd_res_if.source         out_res
);

  fmsd_pkg::dp_cmd_t cmd;
  fmsd_pkg::dp_sts_t sts;
  logic              in_ready;

  // Config words always taken; writes must come only while block idle (unchecked).
  assign cfg_wr.ready = 1'b1;
  assign in_pix.ready = in_ready;

  // The controller steps through the frame-end arithmetic, issuing datapath commands.
  fmsd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_pix.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds the frame size, the running sums and the arithmetic units.
  fmsd_dp #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_valid   (cfg_wr.valid),
    .cfg_index   (cfg_wr.reg_index),
    .cfg_data    (cfg_wr.wr_data),
    .pixel_value (in_pix.pixel_value),
    .out_valid   (out_res.valid),
    .out_ready   (out_res.ready),
    .mean_q8     (out_res.mean_q8),
    .std_dev_q8  (out_res.std_dev_q8)
  );

endmodule
